### rtl/ptp_pkg.sv
// Package for the point-to-point step generator.
// Holds field widths, register indexes, arm codes and the shared-unit control types.
// No dependencies.
package ptp_pkg;

  localparam int POS_W      = 24;
  localparam int FRAC_BITS  = 8;
  localparam int SPEED_W    = 12;
  localparam int THR_W      = 24;
  localparam int ARM_W      = 2;
  localparam int MAG_W      = POS_W + 1;
  localparam int SUMSQ_W    = 2 * MAG_W;
  localparam int PROD_W     = 2 * MAG_W;
  localparam int ROOT_W     = SUMSQ_W / 2 + FRAC_BITS;
  localparam int QUOT_W     = SPEED_W + FRAC_BITS;
  localparam int OUT_W      = QUOT_W + 1;
  localparam int MS_W       = MAG_W + SPEED_W;
  localparam int DIVIDEND_W = MS_W + 2 * FRAC_BITS;
  localparam int SRC_W      = DIVIDEND_W;
  localparam int REM_W      = ROOT_W + 3;
  localparam int CNT_W      = $clog2(ROOT_W + 1);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [ARM_W-1:0] ARM_LEFT  = 2'd0;
  localparam logic [ARM_W-1:0] ARM_RIGHT = 2'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_X = 3'd0,
    REG_TARGET_Y = 3'd1,
    REG_TARGET_Z = 3'd2,
    REG_ARM_SEL  = 3'd3,
    REG_SPEED    = 3'd4,
    REG_STOP_THR = 3'd5
  } cfg_reg_e;

  typedef enum logic {
    OP_SQRT = 1'b0,
    OP_DIV  = 1'b1
  } iter_op_e;

  typedef struct packed {
    logic     start;
    iter_op_e op;
  } iter_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } iter_status_t;

endpackage

### rtl/ptp_if.sv
// Channel interfaces of the step generator: input item, result item, configuration write.
// Depends on ptp_pkg.
interface ptp_in_if;
  import ptp_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] left_x;
  logic signed [POS_W-1:0] left_y;
  logic signed [POS_W-1:0] left_z;
  logic signed [POS_W-1:0] right_x;
  logic signed [POS_W-1:0] right_y;
  logic signed [POS_W-1:0] right_z;
  modport source (output valid, left_x, left_y, left_z, right_x, right_y, right_z,
                  input ready);
  modport sink   (input valid, left_x, left_y, left_z, right_x, right_y, right_z,
                  output ready);
endinterface

interface ptp_out_if;
  import ptp_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] step_x;
  logic signed [OUT_W-1:0] step_y;
  logic signed [OUT_W-1:0] step_z;
  logic                    moving;
  logic                    arm_valid;
  modport source (output valid, step_x, step_y, step_z, moving, arm_valid, input ready);
  modport sink   (input valid, step_x, step_y, step_z, moving, arm_valid, output ready);
endinterface

interface ptp_cfg_if;
  import ptp_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/ptp_mul.sv
// Shared unsigned multiplier with a registered product.
// Depends on ptp_pkg.
module ptp_mul (
  input  logic                        clk_i,
  input  logic [ptp_pkg::MAG_W-1:0]   a_i,
  input  logic [ptp_pkg::MAG_W-1:0]   b_i,
  output logic [ptp_pkg::PROD_W-1:0]  p_o
);
  import ptp_pkg::*;

  logic [PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

### rtl/ptp_root_div.sv
// Iterative square root and restoring divider around one shared compare-subtract.
// One result bit per cycle. Depends on ptp_pkg.
module ptp_root_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ptp_pkg::iter_ctrl_t              ctrl_i,
  input  logic [ptp_pkg::SUMSQ_W-1:0]      radicand_i,
  input  logic [ptp_pkg::DIVIDEND_W-1:0]   dividend_i,
  input  logic [ptp_pkg::ROOT_W-1:0]       divisor_i,
  output logic [ptp_pkg::ROOT_W-1:0]       result_o,
  output ptp_pkg::iter_status_t            status_o
);
  import ptp_pkg::*;

  localparam logic [CNT_W-1:0] SQRT_STEPS = CNT_W'(ROOT_W);
  localparam logic [CNT_W-1:0] DIV_STEPS  = CNT_W'(QUOT_W);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  iter_op_e         op_q;
  logic [REM_W-1:0] rem_q;
  logic [ROOT_W-1:0] acc_q;
  logic [SRC_W-1:0] src_q;
  logic [ROOT_W-1:0] divisor_q;

  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] sub_b;
  logic [REM_W:0]   diff;
  logic [SRC_W-1:0] src_nx;
  logic             ge;

  always_comb begin
    unique case (op_q)
      OP_SQRT: begin
        rem_sh = {rem_q[REM_W-3:0], src_q[SRC_W-1 -: 2]};
        sub_b  = {1'b0, acc_q, 2'b01};
        src_nx = src_q << 2;
      end
      OP_DIV: begin
        rem_sh = {rem_q[REM_W-2:0], src_q[SRC_W-1]};
        sub_b  = {{(REM_W-ROOT_W){1'b0}}, divisor_q};
        src_nx = src_q << 1;
      end
      default: begin
        rem_sh = rem_q;
        sub_b  = '0;
        src_nx = src_q;
      end
    endcase
    diff = {1'b0, rem_sh} - {1'b0, sub_b};
    ge   = ~diff[REM_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= OP_SQRT;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        op_q   <= ctrl_i.op;
        cnt_q  <= (ctrl_i.op == OP_SQRT) ? SQRT_STEPS : DIV_STEPS;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      acc_q     <= '0;
      divisor_q <= divisor_i;
      if (ctrl_i.op == OP_SQRT) begin
        rem_q <= '0;
        src_q <= {radicand_i, {(SRC_W-SUMSQ_W){1'b0}}};
      end else begin
        rem_q <= {{(REM_W-(DIVIDEND_W-QUOT_W)){1'b0}}, dividend_i[DIVIDEND_W-1:QUOT_W]};
        src_q <= {dividend_i[QUOT_W-1:0], {(SRC_W-QUOT_W){1'b0}}};
      end
    end else if (busy_q) begin
      rem_q <= ge ? diff[REM_W-1:0] : rem_sh;
      acc_q <= {acc_q[ROOT_W-2:0], ge};
      src_q <= src_nx;
    end
  end

  assign result_o = acc_q;
  assign status_o = '{busy: busy_q, done: done_q};

endmodule

### rtl/point_to_point_step_generator_core.sv
// Constant-speed point-to-point step generator. An item is taken only while the block is idle;
// a result held up by a waiting previous one keeps the block in S_FIN. At or within the stop
// distance the root and divisions are skipped; when moving, a 33-step scaled square root and
// three 20-step divisions share one compare-subtract unit, and the squares and the speed
// products share one registered multiplier. The result waits in an output register.
// Depends on ptp_pkg, ptp_if, ptp_mul and ptp_root_div.
module point_to_point_step_generator_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  ptp_cfg_if.sink   cfg_i,
  ptp_in_if.sink    in_i,
  ptp_out_if.source out_o
);
  import ptp_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DIFF  = 9'b000000010,
    S_SQ    = 9'b000000100,
    S_CMP   = 9'b000001000,
    S_ROOT  = 9'b000010000,
    S_DMUL  = 9'b000100000,
    S_DWAIT = 9'b001000000,
    S_DIV   = 9'b010000000,
    S_FIN   = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic signed [POS_W-1:0] tgt_q [3];
  logic [ARM_W-1:0]        arm_sel_q;
  logic [SPEED_W-1:0]      speed_q;
  logic [THR_W-1:0]        thr_q;
  logic signed [POS_W-1:0] held_q [3];

  logic [MAG_W-1:0]   mag_q [3];
  logic               neg_q [3];
  logic [SUMSQ_W-1:0] sum_q;
  logic [ROOT_W-1:0]  len_q;
  logic [1:0]         axis_q;
  logic [1:0]         sel_q;
  logic               moving_q;
  logic               arm_ok_q;
  logic [OUT_W-1:0]   res_q [3];

  logic [OUT_W-1:0] out_step_q [3];
  logic             out_moving_q;
  logic             out_arm_q;
  logic             out_valid_q;

  logic [MAG_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] prod;
  iter_ctrl_t        iter_ctrl;
  iter_status_t      iter_status;
  logic [ROOT_W-1:0] iter_res;
  logic              in_acc, out_acc, fin_load, moving_now;
  logic [OUT_W-1:0]  q_ext;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == S_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;
  assign out_acc     = out_o.valid && out_o.ready;
  assign fin_load    = (state_q == S_FIN) && (!out_valid_q || out_o.ready);
  assign moving_now  = sum_q > prod;
  assign q_ext       = {1'b0, iter_res[QUOT_W-1:0]};

  ptp_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  ptp_root_div u_root_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (iter_ctrl),
    .radicand_i (sum_q),
    .dividend_i ({prod[MS_W-1:0], {(2*FRAC_BITS){1'b0}}}),
    .divisor_i  (len_q),
    .result_o   (iter_res),
    .status_o   (iter_status)
  );

  always_comb begin
    mul_a = mag_q[axis_q];
    mul_b = {{(MAG_W-SPEED_W){1'b0}}, speed_q};
    if (state_q == S_SQ) begin
      unique case (sel_q)
        2'd0, 2'd1, 2'd2: begin
          mul_a = mag_q[sel_q];
          mul_b = mag_q[sel_q];
        end
        default: begin
          mul_a = {{(MAG_W-THR_W){1'b0}}, thr_q};
          mul_b = {{(MAG_W-THR_W){1'b0}}, thr_q};
        end
      endcase
    end
  end

  always_comb begin
    iter_ctrl = '{start: 1'b0, op: OP_SQRT};
    if (state_q == S_CMP && moving_now) begin
      iter_ctrl = '{start: 1'b1, op: OP_SQRT};
    end else if (state_q == S_DWAIT) begin
      iter_ctrl = '{start: 1'b1, op: OP_DIV};
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_acc) state_d = S_DIFF;
      S_DIFF:  state_d = S_SQ;
      S_SQ:    if (sel_q == 2'd3) state_d = S_CMP;
      S_CMP:   state_d = moving_now ? S_ROOT : S_FIN;
      S_ROOT:  if (iter_status.done) state_d = S_DMUL;
      S_DMUL:  state_d = S_DWAIT;
      S_DWAIT: state_d = S_DIV;
      S_DIV:   if (iter_status.done) state_d = (axis_q == 2'd2) ? S_FIN : S_DMUL;
      S_FIN:   if (fin_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      arm_sel_q   <= ARM_LEFT;
      speed_q     <= '0;
      thr_q       <= '0;
      for (int k = 0; k < 3; k++) begin
        tgt_q[k]  <= '0;
        held_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (fin_load) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_i.valid) begin
        case (cfg_i.index)
          REG_TARGET_X: tgt_q[0]  <= cfg_i.data[POS_W-1:0];
          REG_TARGET_Y: tgt_q[1]  <= cfg_i.data[POS_W-1:0];
          REG_TARGET_Z: tgt_q[2]  <= cfg_i.data[POS_W-1:0];
          REG_ARM_SEL:  arm_sel_q <= cfg_i.data[ARM_W-1:0];
          REG_SPEED:    speed_q   <= cfg_i.data[SPEED_W-1:0];
          REG_STOP_THR: thr_q     <= cfg_i.data[THR_W-1:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        if (arm_sel_q == ARM_LEFT) begin
          held_q[0] <= in_i.left_x;
          held_q[1] <= in_i.left_y;
          held_q[2] <= in_i.left_z;
        end else if (arm_sel_q == ARM_RIGHT) begin
          held_q[0] <= in_i.right_x;
          held_q[1] <= in_i.right_y;
          held_q[2] <= in_i.right_z;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        arm_ok_q <= (arm_sel_q == ARM_LEFT) || (arm_sel_q == ARM_RIGHT);
      end
      S_DIFF: begin
        for (int k = 0; k < 3; k++) begin
          logic [MAG_W-1:0] dd;
          dd = {tgt_q[k][POS_W-1], tgt_q[k]} - {held_q[k][POS_W-1], held_q[k]};
          neg_q[k] <= dd[MAG_W-1];
          mag_q[k] <= dd[MAG_W-1] ? (~dd + 1'b1) : dd;
          res_q[k] <= '0;
        end
        sum_q <= '0;
        sel_q <= '0;
      end
      S_SQ: begin
        sel_q <= sel_q + 1'b1;
        if (sel_q != 2'd0) sum_q <= sum_q + prod;
      end
      S_CMP: begin
        moving_q <= moving_now;
      end
      S_ROOT: begin
        if (iter_status.done) begin
          len_q  <= iter_res;
          axis_q <= '0;
        end
      end
      S_DIV: begin
        if (iter_status.done) begin
          res_q[axis_q] <= neg_q[axis_q] ? (~q_ext + 1'b1) : q_ext;
          axis_q        <= axis_q + 1'b1;
        end
      end
      S_FIN: begin
        if (fin_load) begin
          for (int k = 0; k < 3; k++) out_step_q[k] <= res_q[k];
          out_moving_q <= moving_q;
          out_arm_q    <= arm_ok_q;
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.step_x    = out_step_q[0];
  assign out_o.step_y    = out_step_q[1];
  assign out_o.step_z    = out_step_q[2];
  assign out_o.moving    = out_moving_q;
  assign out_o.arm_valid = out_arm_q;

  a_no_zero_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DWAIT |-> len_q != '0)
    else $error("division started with zero length");

  a_stopped_zero_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.moving |->
      out_o.step_x == '0 && out_o.step_y == '0 && out_o.step_z == '0)
    else $error("nonzero step while stopped");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("input taken again right after an item");

  a_done_while_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    iter_status.done |-> state_q == S_ROOT || state_q == S_DIV)
    else $error("shared unit finished outside a wait state");

endmodule
